// ===== rtl/cbp_pkg.sv =====
`timescale 1ns / 1ps
package cbp_pkg;

  localparam int STORE_BYTES_DEF  = 4096;
  localparam int MAX_GET_BITS_DEF = 25;

  localparam int CFG_W  = 13;
  localparam int PUT_W  = 32;
  localparam int FW_W   = 6;
  localparam int RV_W   = 25;
  localparam int CNT_W  = 16;
  localparam int BYTE_W = 8;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [PUT_W-1:0]  put_value;
    logic [FW_W-1:0]   field_width;
  } in_item_t;

  typedef struct packed {
    logic [RV_W-1:0]   read_value;
    logic [CNT_W-1:0]  bit_count;
    logic              count_error;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic clearing;
  } seq_status_t;

endpackage

// ===== rtl/cbp_stream_if.sv =====
`timescale 1ns / 1ps
interface cbp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cbp_ram.sv =====
`timescale 1ns / 1ps
module cbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/cbp_seq.sv =====
`timescale 1ns / 1ps
module cbp_seq #(
  parameter int STORE_BYTES  = cbp_pkg::STORE_BYTES_DEF,
  parameter int MAX_GET_BITS = cbp_pkg::MAX_GET_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cbp_stream_if.sink                       in_i,
  cbp_stream_if.source                     out_o,
  input  logic [$clog2(STORE_BYTES+1)-1:0] bb_i,
  input  logic                             restart_i,
  output cbp_pkg::seq_status_t             status_o,
  output logic                             ram_we_o,
  output logic [$clog2(STORE_BYTES)-1:0]   ram_waddr_o,
  output logic [cbp_pkg::BYTE_W-1:0]       ram_wdata_o,
  output logic [$clog2(STORE_BYTES)-1:0]   ram_raddr_o,
  input  logic [cbp_pkg::BYTE_W-1:0]       ram_rdata_i
);
  import cbp_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int CW  = AW + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    wa_q, wa_d, ra_q, ra_d;
  logic [2:0]       wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic             cmd_q, cmd_d;
  logic [FW_W-1:0]  rem_q, rem_d;
  logic [PUT_W-1:0] sh_q, sh_d;
  logic [RV_W-1:0]  res_q, res_d;
  logic             err_q, err_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_a_q, pend_a_d;
  logic [7:0]       pend_m_q, pend_m_d;
  logic [7:0]       pend_b_q, pend_b_d;
  logic [3:0]       pend_c_q, pend_c_d;
  logic [2:0]       pend_lo_q, pend_lo_d;
  logic             fwd_v_q;
  logic [AW-1:0]    fwd_a_q;
  logic [7:0]       fwd_d_q;
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;

  logic [AW-1:0]    cur_a, nxt_a;
  logic [2:0]       cur_p;
  logic [3:0]       pos1, c, lo;
  logic             wrap;
  logic [7:0]       mask, bits, rd_byte, gbits;
  logic [FW_W-1:0]  n_clamp;
  logic [CNT_W:0]   sum, cap;
  logic             done, load;

  always_comb begin
    cur_a = cmd_q ? ra_q : wa_q;
    cur_p = cmd_q ? rp_q : wp_q;
    pos1  = {1'b0, cur_p} + 4'd1;
    c     = (rem_q < FW_W'(pos1)) ? rem_q[3:0] : pos1;
    lo    = pos1 - c;
    wrap  = (c == pos1);
    nxt_a = ((CW'(cur_a) + CW'(1)) >= CW'(bb_i)) ? '0 : cur_a + AW'(1);
    mask  = (8'hFF >> (3'd7 - cur_p)) & (8'hFF << lo[2:0]);
    bits  = sh_q[PUT_W-1 -: 8] >> (3'd7 - cur_p);
    rd_byte = (fwd_v_q && fwd_a_q == pend_a_q) ? fwd_d_q : ram_rdata_i;
    gbits = (rd_byte >> pend_lo_q) & (8'hFF >> (4'd8 - pend_c_q));
    done  = (state_q == ST_RUN) && !pend_q && (rem_q == '0);
    load  = done && (!out_v_q || out_o.ready);
    cap   = (CNT_W+1)'(bb_i) << 3;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wa_d      = wa_q;
    wp_d      = wp_q;
    ra_d      = ra_q;
    rp_d      = rp_q;
    held_d    = held_q;
    cmd_d     = cmd_q;
    rem_d     = rem_q;
    sh_d      = sh_q;
    res_d     = res_q;
    err_d     = err_q;
    pend_d    = 1'b0;
    pend_a_d  = pend_a_q;
    pend_m_d  = pend_m_q;
    pend_b_d  = pend_b_q;
    pend_c_d  = pend_c_q;
    pend_lo_d = pend_lo_q;
    out_v_d   = out_v_q && !out_o.ready;
    out_d     = out_q;
    n_clamp   = '0;
    sum       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = pend_a_q;
    ram_wdata_o = (rd_byte & ~pend_m_q) | (pend_b_q & pend_m_q);
    ram_raddr_o = cur_a;
    in_i.ready  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d = in_i.data.cmd;
          res_d = '0;
          sh_d  = in_i.data.put_value;
          err_d = 1'b0;
          if (in_i.data.cmd == CMD_PUT) begin
            n_clamp = (in_i.data.field_width > FW_W'(PUT_W)) ? FW_W'(PUT_W)
                                                             : in_i.data.field_width;
            sh_d = in_i.data.put_value << (FW_W'(PUT_W) - n_clamp);
            sum  = (CNT_W+1)'(held_q) + (CNT_W+1)'(n_clamp);
            if (sum > cap) begin
              held_d = cap[CNT_W-1:0];
              err_d  = 1'b1;
            end else begin
              held_d = sum[CNT_W-1:0];
            end
          end else begin
            n_clamp = (in_i.data.field_width > FW_W'(MAX_GET_BITS)) ? FW_W'(MAX_GET_BITS)
                                                                    : in_i.data.field_width;
            if (CNT_W'(n_clamp) > held_q) begin
              held_d = '0;
              err_d  = 1'b1;
            end else begin
              held_d = held_q - CNT_W'(n_clamp);
            end
          end
          rem_d   = n_clamp;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pend_q) begin
          if (cmd_q == CMD_PUT) begin
            ram_we_o = 1'b1;
          end else begin
            res_d = (res_q << pend_c_q) | RV_W'(gbits);
          end
        end
        if (rem_q != '0) begin
          pend_d    = 1'b1;
          pend_a_d  = cur_a;
          pend_m_d  = mask;
          pend_b_d  = bits;
          pend_c_d  = c;
          pend_lo_d = lo[2:0];
          rem_d     = rem_q - FW_W'(c);
          sh_d      = sh_q << c;
          if (cmd_q == CMD_PUT) begin
            wp_d = wrap ? 3'd7 : cur_p - c[2:0];
            wa_d = wrap ? nxt_a : cur_a;
          end else begin
            rp_d = wrap ? 3'd7 : cur_p - c[2:0];
            ra_d = wrap ? nxt_a : cur_a;
          end
        end
        if (load) begin
          out_v_d           = 1'b1;
          out_d.read_value  = (cmd_q == CMD_GET) ? res_q : '0;
          out_d.bit_count   = held_q;
          out_d.count_error = err_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (restart_i) begin
      wa_d   = '0;
      wp_d   = 3'd7;
      ra_d   = '0;
      rp_d   = 3'd7;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wa_q    <= '0;
      wp_q    <= 3'd7;
      ra_q    <= '0;
      rp_q    <= 3'd7;
      held_q  <= '0;
      pend_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wa_q    <= wa_d;
      wp_q    <= wp_d;
      ra_q    <= ra_d;
      rp_q    <= rp_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      fwd_v_q <= ram_we_o;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rem_q     <= rem_d;
    sh_q      <= sh_d;
    res_q     <= res_d;
    err_q     <= err_d;
    pend_a_q  <= pend_a_d;
    pend_m_q  <= pend_m_d;
    pend_b_q  <= pend_b_d;
    pend_c_q  <= pend_c_d;
    pend_lo_q <= pend_lo_d;
    fwd_a_q   <= ram_waddr_o;
    fwd_d_q   <= ram_wdata_o;
    out_q     <= out_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.data        = out_q;
  assign status_o.busy     = (state_q == ST_RUN);
  assign status_o.clearing = (state_q == ST_CLEAR);

endmodule

// ===== rtl/circular_bit_packer_unpacker.sv =====
// channel   dir  payload                                   handshake
// in_i      in   cmd, put_value[31:0], field_width[5:0]    valid/ready
// out_o     out  read_value[24:0], bit_count[15:0], error  valid/ready
// cfg       in   cfg_wdata_i[12:0] (buffer_bytes)          cfg_we_i, no wait
//
// An item touching k store bytes, k = 1..5 for a put and 1..4 for a get, passes through the
// single byte port of the store one byte after another; a zero-width item touches none. The
// next transaction is accepted once the result has loaded and the sequencer is back in idle.
// After reset the store is zeroed one byte a cycle, with in_i.ready low.
// A result held in out_o blocks only the completion of the next transaction.
`timescale 1ns / 1ps
module circular_bit_packer_unpacker #(
  parameter int STORE_BYTES  = cbp_pkg::STORE_BYTES_DEF,
  parameter int MAX_GET_BITS = cbp_pkg::MAX_GET_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cbp_pkg::CFG_W-1:0] cfg_wdata_i,
  cbp_stream_if.sink                in_i,
  cbp_stream_if.source              out_o
);
  import cbp_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int BBW = $clog2(STORE_BYTES+1);

  logic [BBW-1:0]    bb_q, bb_d;
  seq_status_t       status;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    bb_d = bb_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        bb_d = BBW'(1);
      end else if (cfg_wdata_i > CFG_W'(STORE_BYTES)) begin
        bb_d = BBW'(STORE_BYTES);
      end else begin
        bb_d = BBW'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q <= BBW'(STORE_BYTES);
    end else begin
      bb_q <= bb_d;
    end
  end

  cbp_seq #(
    .STORE_BYTES  (STORE_BYTES),
    .MAX_GET_BITS (MAX_GET_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .bb_i        (bb_q),
    .restart_i   (cfg_we_i),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  cbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_bb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (bb_q != '0 && bb_q <= BBW'(STORE_BYTES)))
    else $error("buffer size out of range after write");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !in_i.ready)
    else $error("input accepted during store clear");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !in_i.ready)
    else $error("input accepted while a transaction is in progress");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(status.busy))
    else $error("result appeared without a transaction in progress");

endmodule
